FILE: rtl/first_fit_segment_allocator_core_macros.svh
// assertion macros used by the allocator core
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication under asynchronous reset
`define FFSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under asynchronous reset
`define FFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ffsa_pkg.sv
// shared types and constants of the first-fit segment allocator
package ffsa_pkg;

	localparam int ADDR_W     = 12;
	localparam int SIZE_W     = 13;
	localparam int HDR_DEPTH  = 4096;
	localparam logic [SIZE_W-1:0] HEAP_BYTES = 13'd4096;
	localparam logic [SIZE_W-1:0] HDR_BYTES  = 13'd4;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NO_FIT     = 2'd1,
		STAT_NULL_FREE  = 2'd2,
		STAT_TABLE_FULL = 2'd3
	} status_t;

	// one free segment as held by a cell
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] size;
	} seg_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic              cmp_load;
		logic [SIZE_W-1:0] cmp_need;
		logic              alloc_go;
		logic              remove;
		logic [SIZE_W-1:0] need;
		logic              free_go;
		logic [ADDR_W-1:0] new_base;
		logic [SIZE_W-1:0] new_size;
	} cell_cmd_t;

endpackage

FILE: rtl/ffsa_if.sv
// request and response channel interfaces of the allocator
interface ffsa_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [11:0] alloc_size;
	logic [11:0] block_addr;

	modport source (output valid, req_type, alloc_size, block_addr, input ready);
	modport sink (input valid, req_type, alloc_size, block_addr, output ready);
endinterface

interface ffsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] payload_addr;
	logic [12:0] free_total;

	modport source (output valid, status, payload_addr, free_total, input ready);
	modport sink (input valid, status, payload_addr, free_total, output ready);
endinterface

FILE: rtl/ffsa_cell.sv
// one free-segment cell of the ordered segment chain
module ffsa_cell #(
	parameter bit IS_HEAD = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffsa_pkg::cell_cmd_t cmd,
	input  logic                found_in,
	output logic                found_out,
	input  logic                prev_valid,
	input  ffsa_pkg::seg_t      nxt,
	output ffsa_pkg::seg_t      seg,
	output logic                pick,
	output logic                exact
);

	ffsa_pkg::seg_t seg_q;
	logic           ge_q;
	logic           eq_q;
	logic           hit;

	assign seg       = seg_q;
	assign hit       = seg_q.valid && ge_q;
	assign found_out = found_in || hit;
	assign pick      = hit && !found_in;
	assign exact     = pick && eq_q;

	// size compare is taken at accept, the segment does not move before commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (cmd.cmp_load) begin
			ge_q <= seg_q.size >= cmd.cmp_need;
			eq_q <= seg_q.size == cmd.cmp_need;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q.valid <= IS_HEAD;
			seg_q.base  <= '0;
			seg_q.size  <= IS_HEAD ? ffsa_pkg::HEAP_BYTES : '0;
		end else if (cmd.alloc_go) begin
			if (cmd.remove && found_out) begin
				// close up behind the removed segment
				seg_q <= nxt;
			end else if (pick) begin
				seg_q.base <= seg_q.base + cmd.need[ffsa_pkg::ADDR_W-1:0];
				seg_q.size <= seg_q.size - cmd.need;
			end
		end else if (cmd.free_go && !seg_q.valid && prev_valid) begin
			seg_q.valid <= 1'b1;
			seg_q.base  <= cmd.new_base;
			seg_q.size  <= cmd.new_size;
		end
	end

endmodule

FILE: rtl/first_fit_segment_allocator_core.sv
// first-fit free-segment allocator: control, header store and cell chain
// Usage:
// Requests arrive on the req channel (valid/ready), one beat per request:
// req_type 0 allocates alloc_size payload bytes, req_type 1 frees the
// payload at block_addr. Each request gives exactly one response beat on
// the rsp channel with status, payload_addr and the saturated free total.
// A request accepted in the idle state has its response registered at the
// commit edge of the execution state; no new request is taken before that
// commit. The accepting edge reads the block header from the single-port
// header store and latches the size compare in every segment cell; the
// execution state resolves the first fit along the cell chain, and its
// commit edge updates the cells and, for an allocation, writes the header.
// The response sits in an output register: the next request is accepted
// while it waits. If the receiver still holds the previous response in the
// execution state, the block waits there until that beat is taken.
// Reset is asynchronous: the chain holds one segment covering the whole
// heap, the free total is the heap size, and no response is pending. The
// header store is not cleared; freeing a never-allocated address returns
// an unspecified segment size.
module first_fit_segment_allocator_core #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	ffsa_req_if.sink          req,
	ffsa_rsp_if.source        rsp
);

	`include "first_fit_segment_allocator_core_macros.svh"

	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int TOT_W = ffsa_pkg::SIZE_W + $clog2(MAX_SEGMENTS);
	localparam int AW    = ffsa_pkg::ADDR_W;
	localparam int SW    = ffsa_pkg::SIZE_W;

	ffsa_pkg::state_t    state_q;
	ffsa_pkg::state_t    state_d;
	ffsa_pkg::cell_cmd_t cmd;
	ffsa_pkg::seg_t      seg    [MAX_SEGMENTS];
	logic [MAX_SEGMENTS:0]   found;
	logic [MAX_SEGMENTS-1:0] pick;
	logic [MAX_SEGMENTS-1:0] exact;
	logic [MAX_SEGMENTS-1:0] valid_vec;

	logic [SW-1:0]  hdr_mem_q [ffsa_pkg::HDR_DEPTH];
	logic [SW-1:0]  hdr_rd_q;

	logic           req_type_q;
	logic [AW-1:0]  alloc_size_q;
	logic [AW-1:0]  block_addr_q;
	logic [AW-1:0]  hdr_addr_q;
	logic [CNT_W-1:0] count_q;
	logic [TOT_W-1:0] total_q;

	logic           rsp_valid_q;
	logic [1:0]     status_q;
	logic [AW-1:0]  payload_q;
	logic [SW-1:0]  free_total_q;

	logic           accept;
	logic           commit;
	logic           is_alloc;
	logic           alloc_ok;
	logic           null_free;
	logic           table_full;
	logic           free_ok;
	logic           exact_sel;
	logic [AW-1:0]  sel_base;
	logic [SW-1:0]  need;
	logic [SW-1:0]  len4;
	logic [TOT_W-1:0] total_d;
	ffsa_pkg::status_t status_d;

	// ---------------------------------------------------------------- control
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffsa_pkg::ST_IDLE: begin
				if (req.valid) state_d = ffsa_pkg::ST_EXEC;
			end
			ffsa_pkg::ST_EXEC: begin
				if (!rsp_valid_q || rsp.ready) state_d = ffsa_pkg::ST_IDLE;
			end
			default: state_d = ffsa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ffsa_pkg::ST_IDLE: req.ready = 1'b1;
			ffsa_pkg::ST_EXEC: commit    = !rsp_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
				commit    = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ffsa_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q   <= req.req_type;
			alloc_size_q <= req.alloc_size;
			block_addr_q <= req.block_addr;
			hdr_addr_q   <= req.block_addr - ffsa_pkg::HDR_BYTES[AW-1:0];
		end
	end

	// ----------------------------------------------------------- header store
	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_rd_q <= hdr_mem_q[req.block_addr - ffsa_pkg::HDR_BYTES[AW-1:0]];
		end
		if (commit && alloc_ok) begin
			hdr_mem_q[sel_base] <= {1'b0, alloc_size_q};
		end
	end

	// ------------------------------------------------------------- cell chain
	assign need = {1'b0, alloc_size_q} + ffsa_pkg::HDR_BYTES;
	assign len4 = hdr_rd_q + ffsa_pkg::HDR_BYTES;

	assign is_alloc   = !req_type_q;
	assign alloc_ok   = is_alloc && found[MAX_SEGMENTS];
	assign null_free  = !is_alloc && (block_addr_q == '0);
	assign table_full = !is_alloc && !null_free && (count_q == CNT_W'(MAX_SEGMENTS));
	assign free_ok    = !is_alloc && !null_free && !table_full;

	always_comb begin
		cmd.cmp_load = accept;
		cmd.cmp_need = {1'b0, req.alloc_size} + ffsa_pkg::HDR_BYTES;
		cmd.alloc_go = commit && alloc_ok;
		cmd.remove   = exact_sel;
		cmd.need     = need;
		cmd.free_go  = commit && free_ok;
		cmd.new_base = hdr_addr_q;
		cmd.new_size = len4;
	end

	assign found[0] = 1'b0;

	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		logic           prev_valid;
		ffsa_pkg::seg_t nxt;

		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_valid = seg[i-1].valid;
		end

		if (i == MAX_SEGMENTS - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = seg[i+1];
		end

		ffsa_cell #(
			.IS_HEAD (i == 0)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.found_in   (found[i]),
			.found_out  (found[i+1]),
			.prev_valid (prev_valid),
			.nxt        (nxt),
			.seg        (seg[i]),
			.pick       (pick[i]),
			.exact      (exact[i])
		);

		assign valid_vec[i] = seg[i].valid;
	end

	always_comb begin
		sel_base  = '0;
		exact_sel = 1'b0;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			sel_base  = sel_base | ({AW{pick[i]}} & seg[i].base);
			exact_sel = exact_sel | exact[i];
		end
	end

	// ------------------------------------------------------ count and total
	always_comb begin
		total_d = total_q;
		if (alloc_ok)     total_d = total_q - TOT_W'(need);
		else if (free_ok) total_d = total_q + TOT_W'(len4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			total_q <= TOT_W'(ffsa_pkg::HEAP_BYTES);
		end else if (commit) begin
			total_q <= total_d;
			if (alloc_ok && exact_sel) count_q <= count_q - CNT_W'(1);
			else if (free_ok)          count_q <= count_q + CNT_W'(1);
		end
	end

	// -------------------------------------------------------- response beat
	always_comb begin
		if (is_alloc) status_d = alloc_ok ? ffsa_pkg::STAT_OK : ffsa_pkg::STAT_NO_FIT;
		else if (null_free)  status_d = ffsa_pkg::STAT_NULL_FREE;
		else if (table_full) status_d = ffsa_pkg::STAT_TABLE_FULL;
		else                 status_d = ffsa_pkg::STAT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= status_d;
			payload_q    <= alloc_ok ? sel_base + ffsa_pkg::HDR_BYTES[AW-1:0] : '0;
			free_total_q <= (total_d >= TOT_W'(ffsa_pkg::HEAP_BYTES)) ?
				ffsa_pkg::HEAP_BYTES : total_d[SW-1:0];
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.payload_addr = payload_q;
	assign rsp.free_total   = free_total_q;

	// ------------------------------------------------------------ assertions
	`FFSA_ASSERT_NOW(a_count_matches_cells, clk, arst_n, 1'b1,
		$countones(valid_vec) == count_q, "segment count disagrees with valid cells")
	`FFSA_ASSERT_NOW(a_single_pick, clk, arst_n, 1'b1,
		$onehot0(pick), "more than one cell picked as first fit")
	`FFSA_ASSERT_NEXT(a_accept_to_exec, clk, arst_n, accept,
		state_q == ffsa_pkg::ST_EXEC, "accepted request did not enter execution")
	`FFSA_ASSERT_NEXT(a_remove_shrinks_count, clk, arst_n, commit && alloc_ok && exact_sel,
		count_q == $past(count_q) - CNT_W'(1), "exact fit did not drop a segment")
	`FFSA_ASSERT_NOW(a_total_saturated, clk, arst_n, rsp_valid_q,
		free_total_q <= ffsa_pkg::HEAP_BYTES, "free total above heap size")

endmodule
